// ===== rtl/core/fds_pkg.sv =====
// Package for the Forth data-stack unit: command and status codes,
// shared unit operations and default sizes. No dependencies.
`timescale 1ns / 1ps

package fds_pkg;

  localparam int StackDepthDefault = 64;
  localparam int ValueWidth        = 32;
  localparam int EntryWidth        = ValueWidth + 1;
  localparam int DepthOutWidth     = 7;

  localparam logic [2:0] CmdPush  = 3'd0;
  localparam logic [2:0] CmdAdd   = 3'd1;
  localparam logic [2:0] CmdSub   = 3'd2;
  localparam logic [2:0] CmdMul   = 3'd3;
  localparam logic [2:0] CmdDrop  = 3'd4;
  localparam logic [2:0] CmdSwap  = 3'd5;
  localparam logic [2:0] CmdPrint = 3'd6;
  localparam logic [2:0] CmdDup   = 3'd7;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StUnder = 2'd1;
  localparam logic [1:0] StType  = 2'd2;
  localparam logic [1:0] StOver  = 2'd3;

  typedef enum logic [1:0] {
    AluAdd,
    AluSub,
    AluMul
  } alu_op_e;

  typedef struct packed {
    logic [1:0]            status;
    logic                  print_valid;
    logic [ValueWidth-1:0] print_value;
    logic [DepthOutWidth-1:0] depth;
  } rsp_t;

endpackage

// ===== rtl/core/fds_if.sv =====
// Valid/ready channel interfaces for the Forth data-stack unit:
// command words in, response words out. Depends on fds_pkg.
`timescale 1ns / 1ps

interface fds_cmd_if
  import fds_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic [2:0]                   command;
  logic signed [ValueWidth-1:0] push_value;
  logic                         push_is_symbol;

  modport source (output valid, command, push_value, push_is_symbol, input ready);
  modport sink   (input valid, command, push_value, push_is_symbol, output ready);
endinterface

interface fds_rsp_if
  import fds_pkg::*;
();
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic                            print_valid;
  logic signed [ValueWidth-1:0]    print_value;
  logic [DepthOutWidth-1:0]        depth;

  modport source (output valid, status, print_valid, print_value, depth, input ready);
  modport sink   (input valid, status, print_valid, print_value, depth, output ready);
endinterface

// ===== rtl/core/forth_data_stack_unit.sv =====
// Top level of the Forth data-stack unit: sequencer, stack pointer and
// response register. Depends on fds_pkg, fds_if, fds_stack_mem, fds_alu.
`timescale 1ns / 1ps

// Executes one Forth stack command per input word and returns one response
// word with status, print data and the stack depth after the command. After
// the edge that accepts the command, the unit steps through the states STop,
// SExec, SSwap2 (swap only) and SDone, and loads the response into the output
// register on leaving SDone; it takes a new command only in SIdle. The single
// read port of the stack memory sets this sequence: the top entry and the
// second entry are read one after the other, then the shared ALU and write
// port finish the command. The unit accepts no new command until the previous
// response has been loaded into the output register, so a response that is not
// taken stalls the input; that register lets the next command start while the
// response waits to be taken. A failing command leaves the stack unchanged; no
// clearing pass is needed after reset.
module forth_data_stack_unit
  import fds_pkg::*;
#(
  parameter int STACK_DEPTH = StackDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fds_cmd_if.sink       cmd_i,
  fds_rsp_if.source     rsp_o
);

  localparam int Aw = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int Pw = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] STop   = 3'd1;
  localparam logic [2:0] SExec  = 3'd2;
  localparam logic [2:0] SSwap2 = 3'd3;
  localparam logic [2:0] SDone  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [Pw-1:0]         sp_q, sp_d;
  logic [2:0]            cmd_q;
  logic [ValueWidth-1:0] val_q;
  logic                  tag_q;
  logic [EntryWidth-1:0] top_q;
  rsp_t                  res_q, res_d;
  rsp_t                  out_q;
  logic                  out_valid_q;

  logic                  mem_we;
  logic [Aw-1:0]         mem_waddr;
  logic [EntryWidth-1:0] mem_wdata;
  logic                  mem_re;
  logic [Aw-1:0]         mem_raddr;
  logic [EntryWidth-1:0] mem_rdata;

  alu_op_e               alu_op;
  logic [ValueWidth-1:0] alu_res;

  logic [Pw-1:0]         sp_m1, sp_m2, sp_p1;
  logic                  lt1, lt2, full;
  logic                  in_fire, out_free;
  logic [31:0]           sp_ext;

  assign sp_m1 = sp_q - Pw'(1);
  assign sp_m2 = sp_q - Pw'(2);
  assign sp_p1 = sp_q + Pw'(1);
  assign lt1   = (sp_q == '0);
  assign lt2   = (sp_q < Pw'(2));
  assign full  = (sp_q == Pw'(STACK_DEPTH));

  assign cmd_i.ready = (state_q == SIdle);
  assign in_fire     = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  fds_stack_mem #(
    .StackDepth(STACK_DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    case (cmd_q)
      CmdSub:  alu_op = AluSub;
      CmdMul:  alu_op = AluMul;
      default: alu_op = AluAdd;
    endcase
  end

  fds_alu u_alu (
    .op_i (alu_op),
    .sec_i(mem_rdata[ValueWidth-1:0]),
    .top_i(top_q[ValueWidth-1:0]),
    .res_o(alu_res)
  );

  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = sp_q[Aw-1:0];
    mem_wdata = top_q;
    mem_re    = 1'b0;
    mem_raddr = sp_m1[Aw-1:0];
    sp_ext    = '0;

    case (state_q)
      SIdle: begin
        if (in_fire) begin
          mem_re  = 1'b1;
          state_d = STop;
        end
      end
      STop: begin
        // top entry arrives now; fetch the second
        mem_re    = 1'b1;
        mem_raddr = sp_m2[Aw-1:0];
        state_d   = SExec;
      end
      SExec: begin
        res_d.status      = StOk;
        res_d.print_valid = 1'b0;
        res_d.print_value = '0;
        state_d           = SDone;
        case (cmd_q)
          CmdPush: begin
            if (full) begin
              res_d.status = StOver;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {tag_q, val_q};
              sp_d      = sp_p1;
            end
          end
          CmdAdd, CmdSub, CmdMul: begin
            if (lt2) begin
              res_d.status = StUnder;
            end else if (top_q[ValueWidth] || mem_rdata[ValueWidth]) begin
              res_d.status = StType;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = sp_m2[Aw-1:0];
              mem_wdata = {1'b0, alu_res};
              sp_d      = sp_m1;
            end
          end
          CmdDrop: begin
            if (lt1) begin
              res_d.status = StUnder;
            end else begin
              sp_d = sp_m1;
            end
          end
          CmdSwap: begin
            if (lt2) begin
              res_d.status = StUnder;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = sp_m1[Aw-1:0];
              mem_wdata = mem_rdata;
              state_d   = SSwap2;
            end
          end
          CmdPrint: begin
            if (lt1) begin
              res_d.status = StUnder;
            end else if (top_q[ValueWidth]) begin
              res_d.status = StType;
            end else begin
              res_d.print_valid = 1'b1;
              res_d.print_value = top_q[ValueWidth-1:0];
              sp_d              = sp_m1;
            end
          end
          default: begin
            if (lt1) begin
              res_d.status = StUnder;
            end else if (full) begin
              res_d.status = StOver;
            end else begin
              mem_we = 1'b1;
              sp_d   = sp_p1;
            end
          end
        endcase
        sp_ext      = 32'(sp_d);
        res_d.depth = sp_ext[DepthOutWidth-1:0];
      end
      SSwap2: begin
        mem_we    = 1'b1;
        mem_waddr = sp_m2[Aw-1:0];
        mem_wdata = top_q;
        state_d   = SDone;
      end
      SDone: begin
        // hold until the output register is free
        if (out_free) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      if (state_q == SDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_i.command;
      val_q <= cmd_i.push_value;
      tag_q <= cmd_i.push_is_symbol;
    end
    if (state_q == STop) begin
      top_q <= mem_rdata;
    end
    res_q <= res_d;
    if (state_q == SDone && out_free) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.print_valid = out_q.print_valid;
  assign rsp_o.print_value = out_q.print_value;
  assign rsp_o.depth       = out_q.depth;

endmodule

// ===== rtl/core/fds_stack_mem.sv =====
// Stack storage for the Forth data-stack unit: one write port and one
// registered read port. Depends on fds_pkg.
`timescale 1ns / 1ps

module fds_stack_mem
  import fds_pkg::*;
#(
  parameter int StackDepth = StackDepthDefault,
  localparam int Aw = (StackDepth > 1) ? $clog2(StackDepth) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [Aw-1:0]         waddr_i,
  input  logic [EntryWidth-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [Aw-1:0]         raddr_i,
  output logic [EntryWidth-1:0] rdata_o
);

  logic [EntryWidth-1:0] mem_q [StackDepth];
  logic [EntryWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fds_alu.sv =====
// Shared arithmetic unit of the Forth data-stack unit: add, subtract and
// multiply with 32-bit wraparound. Depends on fds_pkg.
`timescale 1ns / 1ps

module fds_alu
  import fds_pkg::*;
(
  input  alu_op_e               op_i,
  input  logic [ValueWidth-1:0] sec_i,
  input  logic [ValueWidth-1:0] top_i,
  output logic [ValueWidth-1:0] res_o
);

  logic [2*ValueWidth-1:0] prod;

  assign prod = {{ValueWidth{1'b0}}, sec_i} * {{ValueWidth{1'b0}}, top_i};

  always_comb begin
    case (op_i)
      AluAdd:  res_o = sec_i + top_i;
      AluSub:  res_o = sec_i - top_i;
      AluMul:  res_o = prod[ValueWidth-1:0];
      default: res_o = sec_i + top_i;
    endcase
  end

endmodule
